FILE: src/mma_pkg.sv
// Package: shared constants, types and codes for the matrix multiply-accumulate block
`default_nettype none
package mma_pkg;
    localparam int MAX_DIM = 16;
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        CMD_LOAD_A  = 3'd0,
        CMD_LOAD_B  = 3'd1,
        CMD_LOAD_C  = 3'd2,
        CMD_COMPUTE = 3'd3,
        CMD_READ_C  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_TRANSPOSE_A = 3'd0,
        REG_TRANSPOSE_B = 3'd1,
        REG_ROWS_M      = 3'd2,
        REG_COLS_N      = 3'd3,
        REG_DEPTH_K     = 3'd4,
        REG_ALPHA       = 3'd5,
        REG_BETA        = 3'd6
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INIT,
        ST_MAC,
        ST_WRITE,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             load_c;
        logic             read_c;
        logic             init_acc;
        logic             mac;
        logic             write_c;
        logic             respond;
        logic             resp_from_read;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic mac_drained;
    } t_stat;
endpackage
`default_nettype wire

FILE: src/mma_ctrl.sv
// Controller: command sequencing and the i, j, k walk of the compute command
`default_nettype none
module mma_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [2:0]                i_cmd,
    input  wire logic [mma_pkg::DIM_W-1:0] i_m,
    input  wire logic [mma_pkg::DIM_W-1:0] i_n,
    input  wire logic [mma_pkg::DIM_W-1:0] i_k,
    input  wire mma_pkg::t_stat            i_stat,
    output mma_pkg::t_ctrl                 o_ctrl
);
    import mma_pkg::*;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic accept;
    logic last_k, last_j, last_i, empty;

    assign accept = start && !busy;
    assign last_k = ({1'b0, r_k} == i_k - DIM_W'(1));
    assign last_j = ({1'b0, r_j} == i_n - DIM_W'(1));
    assign last_i = ({1'b0, r_i} == i_m - DIM_W'(1));
    assign empty  = (i_m == '0) || (i_n == '0);

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_READ_C: n_state = ST_READ;
                        CMD_COMPUTE: begin
                            n_i = '0;
                            n_j = '0;
                            n_state = empty ? ST_DONE : ST_INIT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_INIT: begin
                n_k = '0;
                n_state = (i_k == '0) ? ST_WRITE : ST_MAC;
            end
            ST_MAC: begin
                n_k = r_k + IDX_W'(1);
                if (last_k) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_stat.mac_drained) begin
                    if (last_j) begin
                        n_j = '0;
                        n_i = r_i + IDX_W'(1);
                        n_state = last_i ? ST_DONE : ST_INIT;
                    end else begin
                        n_j = r_j + IDX_W'(1);
                        n_state = ST_INIT;
                    end
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.i = r_i;
        o_ctrl.j = r_j;
        o_ctrl.k = r_k;
        busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_ctrl.load_a  = (i_cmd == CMD_LOAD_A);
                    o_ctrl.load_b  = (i_cmd == CMD_LOAD_B);
                    o_ctrl.load_c  = (i_cmd == CMD_LOAD_C);
                    o_ctrl.read_c  = (i_cmd == CMD_READ_C);
                    o_ctrl.respond = !(i_cmd inside {CMD_READ_C, CMD_COMPUTE});
                end
            end
            ST_READ: begin
                o_ctrl.respond = 1'b1;
                o_ctrl.resp_from_read = 1'b1;
            end
            ST_INIT:  o_ctrl.init_acc = 1'b1;
            ST_MAC:   o_ctrl.mac = 1'b1;
            ST_WRITE: o_ctrl.write_c = i_stat.mac_drained;
            ST_DONE:  o_ctrl.respond = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
        end
    end

`ifndef SYNTH
    a_write_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.write_c |-> r_state == ST_WRITE)
        else $error("C write outside the walk");
    a_read_responds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.read_c |=> o_ctrl.respond && o_ctrl.resp_from_read)
        else $error("read did not respond next cycle");
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> !busy)
        else $error("did not return to idle");
`endif
endmodule
`default_nettype wire

FILE: src/mma_dp.sv
// Datapath: operand stores, scaled multiply-accumulate pipeline and result register
`default_nettype none
module mma_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mma_pkg::t_ctrl             i_ctrl,
    input  wire logic [mma_pkg::IDX_W-1:0]  i_row,
    input  wire logic [mma_pkg::IDX_W-1:0]  i_col,
    input  wire logic signed [15:0]         i_operand,
    input  wire logic signed [31:0]         i_init,
    input  wire logic                       i_in_extent,
    input  wire logic                       i_tr_a,
    input  wire logic                       i_tr_b,
    input  wire logic signed [15:0]         i_alpha,
    input  wire logic signed [31:0]         i_beta,
    output mma_pkg::t_stat                  o_stat,
    output logic                            o_valid,
    output logic signed [31:0]              o_read_value,
    output logic                            o_status
);
    import mma_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    // wide enough for C + beta + MAX_DIM scaled products of up to 2^37
    localparam int ACC_W = 42 + $clog2(MAX_DIM + 1);

    logic signed [15:0] r_a_mem [DEPTH];
    logic signed [15:0] r_b_mem [DEPTH];
    logic signed [31:0] r_c_mem [DEPTH];

    logic [ADDR_W-1:0] a_addr, b_addr, c_addr, in_addr;
    logic signed [15:0] r_a_q, r_b_q;
    logic signed [31:0] r_c_q;
    logic r_ab_v, r_p1_v, r_p2_v;
    logic signed [31:0] r_p1;
    logic signed [47:0] r_p2;
    logic signed [ACC_W-1:0] r_acc, sum_in;
    logic r_init_pend;
    logic r_read_st, r_resp_st;
    logic signed [31:0] sat;
    localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(64'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] MINV = -ACC_W'(64'sh80000000);

    assign in_addr = {i_row, i_col};
    assign a_addr = i_tr_a ? {i_ctrl.k, i_ctrl.i} : {i_ctrl.i, i_ctrl.k};
    assign b_addr = i_tr_b ? {i_ctrl.j, i_ctrl.k} : {i_ctrl.k, i_ctrl.j};
    assign c_addr = (i_ctrl.init_acc || i_ctrl.write_c) ? {i_ctrl.i, i_ctrl.j} : in_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_a) r_a_mem[in_addr] <= i_operand;
        r_a_q <= r_a_mem[a_addr];
    end
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_b) r_b_mem[in_addr] <= i_operand;
        r_b_q <= r_b_mem[b_addr];
    end
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_c) r_c_mem[c_addr] <= i_init;
        else if (i_ctrl.write_c) r_c_mem[c_addr] <= sat;
        r_c_q <= r_c_mem[c_addr];
    end

    // stage 1: A*B, stage 2: *alpha then floor >>8 at accumulate
    always_ff @(posedge i_clk) begin
        r_p1 <= 32'(r_a_q * r_b_q);
        r_p2 <= 48'(r_p1 * i_alpha);
    end

    assign sum_in = r_init_pend ? (ACC_W'(r_c_q) + ACC_W'(i_beta)) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ab_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_init_pend <= 1'b0;
            o_valid <= 1'b0;
            r_read_st <= 1'b0;
        end else begin
            r_ab_v <= i_ctrl.mac;
            r_p1_v <= r_ab_v;
            r_p2_v <= r_p1_v;
            r_read_st <= i_ctrl.read_c;
            if (i_ctrl.init_acc) r_init_pend <= 1'b1;
            else if (r_init_pend) r_init_pend <= 1'b0;
            o_valid <= i_ctrl.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init_pend || r_p2_v)
            r_acc <= sum_in + (r_p2_v ? ACC_W'(r_p2 >>> 8) : '0);
        if (i_ctrl.read_c || i_ctrl.load_c) r_resp_st <= !i_in_extent;
        else if (!r_read_st) r_resp_st <= 1'b0;
        if (i_ctrl.respond) begin
            o_read_value <= i_ctrl.resp_from_read && !r_resp_st ? r_c_q : '0;
            o_status <= i_ctrl.resp_from_read ? r_resp_st
                      : (i_ctrl.load_c ? !i_in_extent : 1'b0);
        end
    end

    assign sat = (r_acc > MAXV) ? 32'sh7FFFFFFF
               : (r_acc < MINV) ? 32'sh80000000 : 32'(r_acc);
    assign o_stat.mac_drained = !(r_ab_v || r_p1_v || r_p2_v || r_init_pend || i_ctrl.mac);

`ifndef SYNTH
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_v |=> r_p2_v)
        else $error("product pipeline lost a stage");
    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.write_c |-> !(r_ab_v || r_p1_v || r_p2_v))
        else $error("C written before products drained");
    a_one_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid || $past(i_ctrl.respond))
        else $error("stray response");
`endif
endmodule
`default_nettype wire

FILE: src/matrix_multiply_accumulate_top.sv
// Top level: matrix multiply-accumulate with transpose options
// Usage:
//   Command channel: start with cmd, row_index, col_index, operand_value,
//   initial_sum; an item is taken at a clock edge with start high, busy low.
//   Each item gives one result, o_done high for one cycle with o_read_value
//   and o_status; the receiver cannot stall it.
//   Loads of A, B and C: result in the cycle after the item, a new item may
//   follow in the next cycle.
//   Read C: result after the registered store read and the read state.
//   Compute: each C element goes through store read, two multiplier stages,
//   accumulate and write back on the single multiply-accumulate unit.
//   Configuration: i_cfg_valid/o_cfg_ready write channel with i_cfg_index
//   and i_cfg_data; ready is always high. Registers reset to no transpose,
//   16x16x16, alpha 1.0, beta 0. Stores are not cleared by reset.
//   Reset: synchronous, active low; the controller returns to idle.
`default_nettype none
module matrix_multiply_accumulate_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_cmd,
    input  wire logic [3:0]         i_row_index,
    input  wire logic [3:0]         i_col_index,
    input  wire logic signed [15:0] i_operand_value,
    input  wire logic signed [31:0] i_initial_sum,
    output logic                    o_done,
    output logic signed [31:0]      o_read_value,
    output logic                    o_status,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import mma_pkg::*;

    logic r_tr_a, r_tr_b;
    logic [4:0] r_m, r_n, r_k;
    logic signed [15:0] r_alpha;
    logic signed [31:0] r_beta;
    logic [DIM_W-1:0] m_c, n_c, k_c;
    logic in_extent;
    t_ctrl ctrl;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr_a <= 1'b0;
            r_tr_b <= 1'b0;
            r_m <= 5'd16;
            r_n <= 5'd16;
            r_k <= 5'd16;
            r_alpha <= 16'sd256;
            r_beta <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TRANSPOSE_A: r_tr_a <= i_cfg_data[0];
                REG_TRANSPOSE_B: r_tr_b <= i_cfg_data[0];
                REG_ROWS_M:      r_m <= i_cfg_data[4:0];
                REG_COLS_N:      r_n <= i_cfg_data[4:0];
                REG_DEPTH_K:     r_k <= i_cfg_data[4:0];
                REG_ALPHA:       r_alpha <= i_cfg_data[15:0];
                REG_BETA:        r_beta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_c = (r_m > 5'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_m);
    assign n_c = (r_n > 5'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_n);
    assign k_c = (r_k > 5'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_k);
    assign in_extent = (DIM_W'(i_row_index) < m_c) && (DIM_W'(i_col_index) < n_c);

    mma_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_m(m_c), .i_n(n_c), .i_k(k_c),
        .i_stat(stat), .o_ctrl(ctrl)
    );

    mma_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl),
        .i_row(i_row_index), .i_col(i_col_index),
        .i_operand(i_operand_value), .i_init(i_initial_sum),
        .i_in_extent(in_extent), .i_tr_a(r_tr_a), .i_tr_b(r_tr_b),
        .i_alpha(r_alpha), .i_beta(r_beta), .o_stat(stat),
        .o_valid(o_done), .o_read_value(o_read_value), .o_status(o_status)
    );
endmodule
`default_nettype wire
